>>> rtl/hlik_pkg.sv
// Hexapod leg-length IK: shared constants, anchor tables, CORDIC angle table
// and the rotation-matrix product schedule.
// No dependencies.
package hlik_pkg;

  localparam int FRAC_BITS_DEF = 12;
  localparam int NUM_LEGS      = 6;
  localparam int CORDIC_ITERS  = 24;
  localparam int QUEUE_DEPTH   = 2;
  localparam int ZW            = 32;

  localparam logic [13:0] HOME_RESET = 14'd8448;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [34:0] Q30_PI      = 35'sd3373259426;
  localparam logic signed [34:0] Q30_HALF_PI = 35'sd1686629713;

  localparam logic signed [31:0] BX  = 32'sd1673797854;
  localparam logic signed [31:0] BY  = 32'sd966367642;
  localparam logic signed [31:0] BY2 = 32'sd1932735283;
  localparam logic signed [31:0] BZ  = 32'sd268435456;
  localparam logic signed [31:0] PA  = 32'sd1024987669;
  localparam logic signed [31:0] PB  = 32'sd375171525;
  localparam logic signed [31:0] PC  = 32'sd1400159194;
  localparam logic signed [31:0] PZ  = -32'sd53687091;

  localparam logic [3:0] DST_CYSP = 4'd9;
  localparam logic [3:0] DST_SYSP = 4'd10;
  localparam logic [3:0] MAT_LAST = 4'd13;

  typedef enum logic [2:0] {
    SRC_SR, SRC_CR, SRC_SP, SRC_CP, SRC_SY, SRC_CY, SRC_CYSP, SRC_SYSP
  } src_t;

  typedef struct packed {
    src_t       a;
    src_t       b;
    logic       neg;
    logic       first;
    logic       add_hold;
    logic [3:0] dest;
  } mat_op_t;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0:  r = 34'sd843314857;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043837;
      5'd3:  r = 34'sd133525159;
      5'd4:  r = 34'sd67021687;
      5'd5:  r = 34'sd33543515;
      5'd6:  r = 34'sd16775851;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194283;
      5'd9:  r = 34'sd2097149;
      default: r = 34'sd1 <<< (30 - i);
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] base_coord(input logic [2:0] leg,
                                                    input logic [1:0] k);
    logic signed [31:0] r;
    r = '0;
    if (k == 2'd2) begin
      r = BZ;
    end else if (k == 2'd0) begin
      case (leg)
        3'd0, 3'd5: r = BX;
        3'd2, 3'd3: r = -BX;
        default:    r = '0;
      endcase
    end else begin
      case (leg)
        3'd0, 3'd2: r = BY;
        3'd1:       r = BY2;
        3'd3, 3'd5: r = -BY;
        3'd4:       r = -BY2;
        default:    r = '0;
      endcase
    end
    return r;
  endfunction

  function automatic logic signed [31:0] plat_coord(input logic [2:0] leg,
                                                    input logic [1:0] k);
    logic signed [31:0] r;
    r = '0;
    if (k == 2'd2) begin
      r = PZ;
    end else if (k == 2'd0) begin
      case (leg)
        3'd0, 3'd5: r = PA;
        3'd1, 3'd4: r = PB;
        3'd2, 3'd3: r = -PC;
        default:    r = '0;
      endcase
    end else begin
      case (leg)
        3'd0:  r = PA;
        3'd1:  r = PC;
        3'd2:  r = PB;
        3'd3:  r = -PB;
        3'd4:  r = -PC;
        3'd5:  r = -PA;
        default: r = '0;
      endcase
    end
    return r;
  endfunction

  // R = Rz(yaw) * Ry(pitch) * Rx(roll), one product per step
  function automatic mat_op_t mat_op(input logic [3:0] idx);
    mat_op_t o;
    o = '{a: SRC_CY, b: SRC_SP, neg: 1'b0, first: 1'b0, add_hold: 1'b0, dest: DST_CYSP};
    case (idx)
      4'd0:  o = '{SRC_CY,   SRC_SP, 1'b0, 1'b0, 1'b0, DST_CYSP};
      4'd1:  o = '{SRC_SY,   SRC_SP, 1'b0, 1'b0, 1'b0, DST_SYSP};
      4'd2:  o = '{SRC_CY,   SRC_CP, 1'b0, 1'b0, 1'b0, 4'd0};
      4'd3:  o = '{SRC_SY,   SRC_CR, 1'b1, 1'b1, 1'b0, 4'd1};
      4'd4:  o = '{SRC_CYSP, SRC_SR, 1'b0, 1'b0, 1'b1, 4'd1};
      4'd5:  o = '{SRC_SY,   SRC_SR, 1'b0, 1'b1, 1'b0, 4'd2};
      4'd6:  o = '{SRC_CYSP, SRC_CR, 1'b0, 1'b0, 1'b1, 4'd2};
      4'd7:  o = '{SRC_SY,   SRC_CP, 1'b0, 1'b0, 1'b0, 4'd3};
      4'd8:  o = '{SRC_CY,   SRC_CR, 1'b0, 1'b1, 1'b0, 4'd4};
      4'd9:  o = '{SRC_SYSP, SRC_SR, 1'b0, 1'b0, 1'b1, 4'd4};
      4'd10: o = '{SRC_CY,   SRC_SR, 1'b1, 1'b1, 1'b0, 4'd5};
      4'd11: o = '{SRC_SYSP, SRC_CR, 1'b0, 1'b0, 1'b1, 4'd5};
      4'd12: o = '{SRC_CP,   SRC_SR, 1'b0, 1'b0, 1'b0, 4'd7};
      4'd13: o = '{SRC_CP,   SRC_CR, 1'b0, 1'b0, 1'b0, 4'd8};
      default: o = '{SRC_CY, SRC_SP, 1'b0, 1'b0, 1'b0, DST_CYSP};
    endcase
    return o;
  endfunction

endpackage

>>> rtl/hlik_front.sv
// Hexapod leg-length IK front end: accepts a pose, scales translations to
// Q.30 and folds angles into +-pi/2. Depends on hlik_pkg.
module hlik_front #(
  parameter int FRAC_BITS = hlik_pkg::FRAC_BITS_DEF,
  parameter int EW        = 4 * ((((18 + 30 - FRAC_BITS) > 33) ?
                                   (18 + 30 - FRAC_BITS) : 33) + 3) + 99
) (
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] x_pos,
  input  logic signed [15:0] y_pos,
  input  logic signed [15:0] heave,
  input  logic signed [15:0] roll_angle,
  input  logic signed [15:0] pitch_angle,
  input  logic signed [15:0] yaw_angle,
  input  logic [13:0]        home_height,
  input  logic               q_full,
  output logic               q_push,
  output logic [EW-1:0]      q_word
);

  localparam int SH = 30 - FRAC_BITS;
  localparam int VW = (((18 + SH) > 33) ? (18 + SH) : 33) + 3;

  logic signed [VW-1:0] tx, ty, tz, tzr;
  logic signed [17:0]   zsum;
  logic signed [hlik_pkg::ZW-1:0] za, zb, zc;
  logic na, nb, nc;

  function automatic logic [hlik_pkg::ZW:0] fold(input logic signed [15:0] ang);
    logic signed [34:0] zf;
    logic signed [34:0] zr;
    logic               n;
    zf = 35'(ang) <<< 17;
    zr = zf;
    n  = 1'b0;
    if (zf > hlik_pkg::Q30_HALF_PI) begin
      zr = zf - hlik_pkg::Q30_PI;
      n  = 1'b1;
    end else if (zf < -hlik_pkg::Q30_HALF_PI) begin
      zr = zf + hlik_pkg::Q30_PI;
      n  = 1'b1;
    end
    return {n, zr[hlik_pkg::ZW-1:0]};
  endfunction

  assign zsum = $signed({4'b0, home_height}) + 18'(heave);
  assign tx   = VW'(x_pos) <<< SH;
  assign ty   = VW'(y_pos) <<< SH;
  assign tz   = VW'(zsum) <<< SH;
  assign tzr  = VW'($signed({1'b0, home_height})) <<< SH;

  assign {na, za} = fold(roll_angle);
  assign {nb, zb} = fold(pitch_angle);
  assign {nc, zc} = fold(yaw_angle);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_word   = {na, nb, nc, za, zb, zc, tx, ty, tz, tzr};

endmodule

>>> rtl/hlik_queue.sv
// Hexapod leg-length IK: short queue between front end and leg engine.
// No dependencies.
module hlik_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  slots [DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [CW-1:0] count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign rdata     = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        slots[wptr] <= wdata;
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/hlik_cordic.sv
// Hexapod leg-length IK: three-lane rotation-mode CORDIC, one iteration
// per cycle. Depends on hlik_pkg.
module hlik_cordic (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic signed [hlik_pkg::ZW-1:0] z_in  [3],
  output logic signed [31:0]             s_out [3],
  output logic signed [31:0]             c_out [3],
  output logic                           done
);

  logic signed [33:0] x [3];
  logic signed [33:0] y [3];
  logic signed [33:0] z [3];
  logic [4:0]         i;
  logic               busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      i    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        i    <= '0;
        for (int l = 0; l < 3; l++) begin
          x[l] <= hlik_pkg::CORDIC_GAIN;
          y[l] <= '0;
          z[l] <= 34'(z_in[l]);
        end
      end else if (busy) begin
        for (int l = 0; l < 3; l++) begin
          if (!z[l][33]) begin
            x[l] <= x[l] - (y[l] >>> i);
            y[l] <= y[l] + (x[l] >>> i);
            z[l] <= z[l] - hlik_pkg::atan_q30(i);
          end else begin
            x[l] <= x[l] + (y[l] >>> i);
            y[l] <= y[l] - (x[l] >>> i);
            z[l] <= z[l] + hlik_pkg::atan_q30(i);
          end
        end
        i <= i + 1'b1;
        if (i == 5'(hlik_pkg::CORDIC_ITERS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      s_out[l] = y[l][31:0];
      c_out[l] = x[l][31:0];
    end
  end

endmodule

>>> rtl/hlik_back.sv
// Hexapod leg-length IK leg engine: CORDIC, rotation matrix, leg vectors,
// squares and bit-serial square root on one shared multiplier.
// Depends on hlik_pkg and hlik_cordic.
module hlik_back #(
  parameter int FRAC_BITS = hlik_pkg::FRAC_BITS_DEF,
  parameter int EW        = 4 * ((((18 + 30 - FRAC_BITS) > 33) ?
                                   (18 + 30 - FRAC_BITS) : 33) + 3) + 99
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  logic [EW-1:0]      q_word,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] leg_off [hlik_pkg::NUM_LEGS],
  output logic               clipped
);

  localparam int SH = 30 - FRAC_BITS;
  localparam int VW = (((18 + SH) > 33) ? (18 + SH) : 33) + 3;
  localparam int RS = SH - 8;
  localparam int LW = VW - RS;
  localparam int QW = LW + 1;
  localparam int SW = 2 * QW;
  localparam int MW = (LW > 32) ? LW : 32;
  localparam int CW = $clog2(QW);
  localparam int TB = 4 * VW;

  localparam logic signed [2*MW-1:0] HALF30 = (2 * MW)'(1) <<< 29;
  localparam logic signed [VW-1:0]   HALFRS = VW'(1) <<< (RS - 1);
  localparam logic [SW-1:0]          SQ_START = SW'(1) << (SW - 2);

  typedef enum logic [3:0] {
    S_IDLE, S_CORDIC, S_MAT_MUL, S_MAT_ACC, S_VINIT, S_LMUL, S_LACC,
    S_VRND, S_SQ, S_SQACC, S_SQRT, S_DONE
  } state_t;

  state_t state;

  logic signed [VW-1:0] tx, ty, tz, tzr;
  logic [2:0]           negs;
  logic signed [31:0]   sr, cr, sp, cp, sy, cy, cysp, sysp, hold;
  logic signed [31:0]   rm [9];
  logic [3:0]           midx;
  logic [2:0]           leg;
  logic [1:0]           k, j;
  logic                 pass;
  logic signed [VW-1:0] v;
  logic signed [LW-1:0] vr;
  logic signed [2*MW-1:0] prod;
  logic [SW-1:0]        acc, rem, root, bitv;
  logic [CW-1:0]        cnt;
  logic [QW-1:0]        len;
  logic                 clip;
  logic signed [15:0]   offs [hlik_pkg::NUM_LEGS];

  logic signed [hlik_pkg::ZW-1:0] cz [3];
  logic signed [31:0]   cs [3];
  logic signed [31:0]   cc [3];
  logic                 cdone;

  hlik_pkg::mat_op_t    op;
  logic signed [31:0]   mat_a, mat_b, mval;
  logic signed [MW-1:0] opa, opb;
  logic signed [2*MW-1:0] prod_next, rsum;
  logic signed [31:0]   r32;
  logic signed [VW-1:0] tsel, vinit;
  logic [3:0]           ridx;
  logic [SW-1:0]        sqv, tsum, rem_next, root_next;
  logic signed [QW:0]   diff, offr;
  logic signed [15:0]   offsat;
  logic                 offclip;

  assign cz[0] = q_word[TB+95:TB+64];
  assign cz[1] = q_word[TB+63:TB+32];
  assign cz[2] = q_word[TB+31:TB];
  assign q_pop = (state == S_IDLE) && q_valid;

  hlik_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (q_pop),
    .z_in  (cz),
    .s_out (cs),
    .c_out (cc),
    .done  (cdone)
  );

  assign op = hlik_pkg::mat_op(midx);

  always_comb begin
    case (op.a)
      hlik_pkg::SRC_SR:   mat_a = sr;
      hlik_pkg::SRC_CR:   mat_a = cr;
      hlik_pkg::SRC_SP:   mat_a = sp;
      hlik_pkg::SRC_CP:   mat_a = cp;
      hlik_pkg::SRC_SY:   mat_a = sy;
      hlik_pkg::SRC_CY:   mat_a = cy;
      hlik_pkg::SRC_CYSP: mat_a = cysp;
      hlik_pkg::SRC_SYSP: mat_a = sysp;
      default:            mat_a = '0;
    endcase
    case (op.b)
      hlik_pkg::SRC_SR:   mat_b = sr;
      hlik_pkg::SRC_CR:   mat_b = cr;
      hlik_pkg::SRC_SP:   mat_b = sp;
      hlik_pkg::SRC_CP:   mat_b = cp;
      hlik_pkg::SRC_SY:   mat_b = sy;
      hlik_pkg::SRC_CY:   mat_b = cy;
      hlik_pkg::SRC_CYSP: mat_b = cysp;
      hlik_pkg::SRC_SYSP: mat_b = sysp;
      default:            mat_b = '0;
    endcase
  end

  assign ridx = 4'(k) * 4'd3 + 4'(j);

  always_comb begin
    case (state)
      S_MAT_MUL: begin
        opa = MW'(mat_a);
        opb = MW'(mat_b);
      end
      S_LMUL: begin
        opa = MW'(rm[ridx]);
        opb = MW'(hlik_pkg::plat_coord(leg, j));
      end
      default: begin
        opa = MW'(vr);
        opb = MW'(vr);
      end
    endcase
  end

  assign prod_next = opa * opb;
  assign rsum      = prod + HALF30;
  assign r32       = 32'(rsum >>> 30);
  assign mval      = op.neg ? -r32 : r32;

  always_comb begin
    case (k)
      2'd0:    tsel = pass ? '0 : tx;
      2'd1:    tsel = pass ? '0 : ty;
      default: tsel = pass ? tzr : tz;
    endcase
  end

  assign vinit = tsel - VW'(hlik_pkg::base_coord(leg, k))
               + (pass ? VW'(hlik_pkg::plat_coord(leg, k)) : VW'(0));

  assign sqv       = SW'(prod);
  assign tsum      = root + bitv;
  assign rem_next  = (rem >= tsum) ? rem - tsum : rem;
  assign root_next = (rem >= tsum) ? (root >> 1) + bitv : root >> 1;

  assign diff = $signed({1'b0, len}) - $signed({1'b0, root_next[QW-1:0]});
  assign offr = (diff + (QW + 1)'(128)) >>> 8;

  always_comb begin
    offclip = 1'b0;
    offsat  = 16'(offr);
    if (offr > (QW + 1)'(32767)) begin
      offsat  = 16'sh7fff;
      offclip = 1'b1;
    end else if (offr < -(QW + 1)'(32768)) begin
      offsat  = -16'sh8000;
      offclip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            tzr   <= q_word[VW-1:0];
            tz    <= q_word[2*VW-1:VW];
            ty    <= q_word[3*VW-1:2*VW];
            tx    <= q_word[4*VW-1:3*VW];
            negs  <= q_word[EW-1:EW-3];
            clip  <= 1'b0;
            state <= S_CORDIC;
          end
        end
        S_CORDIC: begin
          if (cdone) begin
            sr    <= negs[2] ? -cs[0] : cs[0];
            cr    <= negs[2] ? -cc[0] : cc[0];
            sp    <= negs[1] ? -cs[1] : cs[1];
            cp    <= negs[1] ? -cc[1] : cc[1];
            sy    <= negs[0] ? -cs[2] : cs[2];
            cy    <= negs[0] ? -cc[2] : cc[2];
            rm[6] <= negs[1] ? cs[1] : -cs[1];
            midx  <= '0;
            state <= S_MAT_MUL;
          end
        end
        S_MAT_MUL: begin
          prod  <= prod_next;
          state <= S_MAT_ACC;
        end
        S_MAT_ACC: begin
          if (op.first) begin
            hold <= mval;
          end else if (op.dest == hlik_pkg::DST_CYSP) begin
            cysp <= mval;
          end else if (op.dest == hlik_pkg::DST_SYSP) begin
            sysp <= mval;
          end else begin
            rm[op.dest] <= op.add_hold ? hold + mval : mval;
          end
          if (midx == hlik_pkg::MAT_LAST) begin
            leg   <= '0;
            pass  <= 1'b0;
            k     <= '0;
            acc   <= '0;
            state <= S_VINIT;
          end else begin
            midx  <= midx + 1'b1;
            state <= S_MAT_MUL;
          end
        end
        S_VINIT: begin
          v     <= vinit;
          j     <= '0;
          state <= pass ? S_VRND : S_LMUL;
        end
        S_LMUL: begin
          prod  <= prod_next;
          state <= S_LACC;
        end
        S_LACC: begin
          v <= v + VW'(rsum >>> 30);
          if (j == 2'd2) begin
            state <= S_VRND;
          end else begin
            j     <= j + 1'b1;
            state <= S_LMUL;
          end
        end
        S_VRND: begin
          vr    <= LW'((v + HALFRS) >>> RS);
          state <= S_SQ;
        end
        S_SQ: begin
          prod  <= prod_next;
          state <= S_SQACC;
        end
        S_SQACC: begin
          if (k == 2'd2) begin
            rem   <= acc + sqv;
            root  <= '0;
            bitv  <= SQ_START;
            cnt   <= '0;
            state <= S_SQRT;
          end else begin
            acc   <= acc + sqv;
            k     <= k + 1'b1;
            state <= S_VINIT;
          end
        end
        S_SQRT: begin
          rem  <= rem_next;
          root <= root_next;
          bitv <= bitv >> 2;
          cnt  <= cnt + 1'b1;
          if (cnt == CW'(QW - 1)) begin
            k   <= '0;
            acc <= '0;
            if (!pass) begin
              len   <= root_next[QW-1:0];
              pass  <= 1'b1;
              state <= S_VINIT;
            end else begin
              offs[leg] <= offsat;
              clip      <= clip | offclip;
              pass      <= 1'b0;
              if (leg == 3'(hlik_pkg::NUM_LEGS - 1)) begin
                state <= S_DONE;
              end else begin
                leg   <= leg + 1'b1;
                state <= S_VINIT;
              end
            end
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            leg_off   <= offs;
            clipped   <= clip;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/hexapod_leg_length_ik_unit.sv
// Hexapod leg-length IK top level: home-height register, front end, queue
// and leg engine. Depends on hlik_pkg, hlik_front, hlik_queue, hlik_back.
//
//   channel  | signals                                        | handshake
//   ---------+------------------------------------------------+----------------
//   pose in  | x_pos y_pos heave roll_angle pitch_angle ...    | in_valid/in_stall
//   legs out | leg_one_offset .. leg_six_offset, clipped       | out_valid/out_stall
//   config   | cfg_wr_data (home_height)                       | cfg_wr_en
//
// One pose runs in order: a pop, the CORDIC, the rotation matrix on the
// shared multiplier, then each leg in turn, mostly two bit-serial square
// roots of 30 steps each at the default (one result bit a cycle), and a
// load of the output register.
// Poses queue two deep ahead of the engine; the front stalls only when full.
// A finished result waits in the output register while the next pose runs.
// Reset is synchronous; home_height returns to 2.0625 m.
module hexapod_leg_length_ik_unit #(
  parameter int FRAC_BITS = hlik_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] x_pos,
  input  logic signed [15:0] y_pos,
  input  logic signed [15:0] heave,
  input  logic signed [15:0] roll_angle,
  input  logic signed [15:0] pitch_angle,
  input  logic signed [15:0] yaw_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] leg_one_offset,
  output logic signed [15:0] leg_two_offset,
  output logic signed [15:0] leg_three_offset,
  output logic signed [15:0] leg_four_offset,
  output logic signed [15:0] leg_five_offset,
  output logic signed [15:0] leg_six_offset,
  output logic               clipped,
  input  logic               cfg_wr_en,
  input  logic [13:0]        cfg_wr_data
);

  localparam int SH = 30 - FRAC_BITS;
  localparam int VW = (((18 + SH) > 33) ? (18 + SH) : 33) + 3;
  localparam int EW = 4 * VW + 99;

  logic [13:0]        home_height;
  logic               q_full, q_push, q_pop, q_valid;
  logic [EW-1:0]      q_in, q_out;
  logic signed [15:0] leg_off [hlik_pkg::NUM_LEGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      home_height <= hlik_pkg::HOME_RESET;
    end else if (cfg_wr_en) begin
      home_height <= cfg_wr_data;
    end
  end

  hlik_front #(.FRAC_BITS(FRAC_BITS), .EW(EW)) u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .x_pos       (x_pos),
    .y_pos       (y_pos),
    .heave       (heave),
    .roll_angle  (roll_angle),
    .pitch_angle (pitch_angle),
    .yaw_angle   (yaw_angle),
    .home_height (home_height),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_word      (q_in)
  );

  hlik_queue #(.W(EW), .DEPTH(hlik_pkg::QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wdata     (q_in),
    .pop       (q_pop),
    .rdata     (q_out),
    .full      (q_full),
    .not_empty (q_valid)
  );

  hlik_back #(.FRAC_BITS(FRAC_BITS), .EW(EW)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_word    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .leg_off   (leg_off),
    .clipped   (clipped)
  );

  assign leg_one_offset   = leg_off[0];
  assign leg_two_offset   = leg_off[1];
  assign leg_three_offset = leg_off[2];
  assign leg_four_offset  = leg_off[3];
  assign leg_five_offset  = leg_off[4];
  assign leg_six_offset   = leg_off[5];

endmodule
